// ----- hw/rtl/bsms_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery sleep mode selector package
// Shared types, register indexes, reset values and limits.
// ----------------------------------------------------------------------------
package bsms_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned MASK_WIDTH      = 11;
   localparam int unsigned LV_COUNT_WIDTH  = 22;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORCE_DEEP_MV          = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORCE_DEEP_SECONDS     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_VOLT_MV            = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_VOLT_MINUTES       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHARGE_IDLE_LIMIT      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURRENT_BLOCK_LIMIT    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_SECONDS_TO_HICCUP = 3'd6;

   localparam logic [15:0] RST_FORCE_DEEP_MV          = 16'd2800;
   localparam logic [15:0] RST_FORCE_DEEP_SECONDS     = 16'd60;
   localparam logic [15:0] RST_LOW_VOLT_MV            = 16'd3000;
   localparam logic [15:0] RST_LOW_VOLT_MINUTES       = 16'd10;
   localparam logic [15:0] RST_CHARGE_IDLE_LIMIT      = 16'd5;
   localparam logic [15:0] RST_CURRENT_BLOCK_LIMIT    = 16'd10;
   localparam logic [15:0] RST_IDLE_SECONDS_TO_HICCUP = 16'd30;

   localparam logic [LV_COUNT_WIDTH-1:0] SECONDS_PER_MINUTE = 22'd60;
   localparam logic [LV_COUNT_WIDTH-1:0] LV_COUNT_MAX       = '1;
   localparam logic [15:0]               CNT16_MAX          = '1;

   localparam int unsigned MASK_CHARGE    = 0;
   localparam int unsigned MASK_DISCHARGE = 1;
   localparam int unsigned MASK_LINK      = 2;
   localparam int unsigned MASK_KEY       = 3;
   localparam int unsigned MASK_FLASH     = 4;
   localparam int unsigned MASK_UPGRADE   = 5;
   localparam int unsigned MASK_FAULT     = 6;
   localparam int unsigned MASK_LED       = 7;
   localparam int unsigned MASK_AGING     = 8;
   localparam int unsigned MASK_AFE       = 9;
   localparam int unsigned MASK_EXTCOMM   = 10;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_HICCUP = 2'd1,
      MODE_NORMAL = 2'd2,
      MODE_DEEP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REQ_NONE   = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_HICCUP = 2'd2,
      REQ_DEEP   = 2'd3
   } request_type;

   typedef struct packed {
      logic [15:0] force_deep_mv;
      logic [15:0] force_deep_seconds;
      logic [15:0] low_volt_mv;
      logic [15:0] low_volt_minutes;
      logic [15:0] charge_idle_limit;
      logic [15:0] current_block_limit;
      logic [15:0] idle_seconds_to_hiccup;
   } cfg_type;

   typedef struct packed {
      logic [15:0] cell_min_mv;
      logic [15:0] charge_current;
      logic [15:0] discharge_current;
      logic        link_busy;
      logic        key_active;
      logic        flash_busy;
      logic        upgrade_active;
      logic        fault_active;
      logic        led_active;
      logic        aging_active;
      logic        afe_blocked;
      logic        ext_comm_seen;
   } item_type;

   typedef struct packed {
      mode_type                power_mode;
      request_type             request_made;
      logic [MASK_WIDTH-1:0]   block_mask;
   } result_type;

   typedef struct packed {
      logic [15:0]               force_count;
      logic [LV_COUNT_WIDTH-1:0] low_volt_count;
      logic [15:0]               idle_count;
      logic                      comm_pending;
      mode_type                  mode;
   } state_type;

endpackage

// ----- hw/rtl/bsms_step.sv -----
// ----------------------------------------------------------------------------
// Sleep decision step
// Block mask, voltage and idle counters and mode update for one item.
// ----------------------------------------------------------------------------
module bsms_step (
   input  bsms_pkg::cfg_type    cfg,
   input  bsms_pkg::item_type   item,
   input  bsms_pkg::state_type  state_cur,
   output bsms_pkg::state_type  state_nxt,
   output bsms_pkg::result_type result
);
   import bsms_pkg::*;

   logic [MASK_WIDTH-1:0]     mask;
   logic                      chg_idle;
   logic                      force_hit;
   logic                      low_hit;
   logic                      pending;
   logic [15:0]               force_inc;
   logic [15:0]               idle_inc;
   logic [LV_COUNT_WIDTH-1:0] lv_inc;
   logic [LV_COUNT_WIDTH-1:0] lv_limit;
   request_type               req;

   assign force_inc = (state_cur.force_count < CNT16_MAX) ?
                      state_cur.force_count + 16'd1 : state_cur.force_count;
   assign idle_inc  = (state_cur.idle_count < CNT16_MAX) ?
                      state_cur.idle_count + 16'd1 : state_cur.idle_count;
   assign lv_inc    = (state_cur.low_volt_count < LV_COUNT_MAX) ?
                      state_cur.low_volt_count + 22'd1 : state_cur.low_volt_count;
   assign lv_limit  = LV_COUNT_WIDTH'(cfg.low_volt_minutes) * SECONDS_PER_MINUTE;

   assign chg_idle  = item.charge_current <= cfg.charge_idle_limit;
   assign force_hit = (item.cell_min_mv <= cfg.force_deep_mv) && chg_idle;
   assign low_hit   = (item.cell_min_mv <= cfg.low_volt_mv) && chg_idle;
   assign pending   = state_cur.comm_pending | item.ext_comm_seen;

   always_comb begin
      mask                      = '0;
      mask[MASK_CHARGE]         = item.charge_current > cfg.current_block_limit;
      mask[MASK_DISCHARGE]      = item.discharge_current > cfg.current_block_limit;
      mask[MASK_LINK]           = item.link_busy;
      mask[MASK_KEY]            = item.key_active;
      mask[MASK_FLASH]          = item.flash_busy;
      mask[MASK_UPGRADE]        = item.upgrade_active;
      mask[MASK_FAULT]          = item.fault_active;
      mask[MASK_LED]            = item.led_active;
      mask[MASK_AGING]          = item.aging_active;
      mask[MASK_AFE]            = item.afe_blocked;

      state_nxt              = state_cur;
      state_nxt.comm_pending = pending;
      req                    = REQ_NONE;

      priority if (force_hit) begin
         state_nxt.idle_count  = '0;
         state_nxt.force_count = force_inc;
         if (force_inc >= cfg.force_deep_seconds) begin
            state_nxt.mode = MODE_DEEP;
            req            = REQ_DEEP;
         end
      end else if (low_hit) begin
         state_nxt.idle_count     = '0;
         state_nxt.low_volt_count = lv_inc;
         if (lv_inc >= lv_limit) begin
            state_nxt.mode = MODE_DEEP;
            req            = REQ_DEEP;
         end
      end else if (item.key_active || item.aging_active) begin
         state_nxt.low_volt_count = '0;
         state_nxt.force_count    = '0;
         state_nxt.idle_count     = '0;
         if (state_cur.mode == MODE_HICCUP) begin
            state_nxt.mode = MODE_NONE;
            req            = REQ_CANCEL;
         end
      end else begin
         state_nxt.low_volt_count = '0;
         state_nxt.force_count    = '0;
         if (mask == '0 && pending) begin
            state_nxt.comm_pending = 1'b0;
            mask[MASK_EXTCOMM]     = 1'b1;
         end
         if (mask != '0) begin
            state_nxt.idle_count = '0;
         end else if (idle_inc >= cfg.idle_seconds_to_hiccup) begin
            state_nxt.idle_count = '0;
            state_nxt.mode       = MODE_HICCUP;
            req                  = REQ_HICCUP;
         end else begin
            state_nxt.idle_count = idle_inc;
         end
      end

      result.power_mode   = state_nxt.mode;
      result.request_made = req;
      result.block_mask   = mask;
   end

endmodule

// ----- hw/rtl/battery_sleep_mode_selector.sv -----
// ----------------------------------------------------------------------------
// Battery sleep mode selector
// Per-tick sleep decision: block mask, deep and hiccup requests.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  cell voltage, currents, activity flags
//  rsp      out        rsp_valid/rsp_stall  power_mode, request_made, block_mask
//  csr      in         csr_wr_en            csr_index, csr_wdata
//
//  One item per cycle sustained while rsp_stall is low; an accepted item is
//  captured in the input register, then decision logic loads the result register.
//  Sleep state updates in the same edge that loads the result register.
//  Synchronous reset clears counters, mode, pending flag and valids, and
//  loads register defaults. A stalled result holds both stages.
// ----------------------------------------------------------------------------
module battery_sleep_mode_selector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [15:0]                           req_cell_min_mv,
   input  logic [15:0]                           req_charge_current,
   input  logic [15:0]                           req_discharge_current,
   input  logic                                  req_link_busy,
   input  logic                                  req_key_active,
   input  logic                                  req_flash_busy,
   input  logic                                  req_upgrade_active,
   input  logic                                  req_fault_active,
   input  logic                                  req_led_active,
   input  logic                                  req_aging_active,
   input  logic                                  req_afe_blocked,
   input  logic                                  req_ext_comm_seen,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_power_mode,
   output logic [1:0]                            rsp_request_made,
   output logic [bsms_pkg::MASK_WIDTH-1:0]       rsp_block_mask,
   input  logic                                  csr_wr_en,
   input  logic [bsms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bsms_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import bsms_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   item_type   item_ff, item_in;
   result_type result_ff;
   result_type step_result;
   logic       in_vld_ff, in_vld_in;
   logic       out_vld_ff, out_vld_in;
   logic       out_take;
   logic       in_take;
   logic       advance;

   assign out_take  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_take;
   assign in_take   = !in_vld_ff || advance;
   assign req_stall = !in_take;

   assign item_in.cell_min_mv       = req_cell_min_mv;
   assign item_in.charge_current    = req_charge_current;
   assign item_in.discharge_current = req_discharge_current;
   assign item_in.link_busy         = req_link_busy;
   assign item_in.key_active        = req_key_active;
   assign item_in.flash_busy        = req_flash_busy;
   assign item_in.upgrade_active    = req_upgrade_active;
   assign item_in.fault_active      = req_fault_active;
   assign item_in.led_active        = req_led_active;
   assign item_in.aging_active      = req_aging_active;
   assign item_in.afe_blocked       = req_afe_blocked;
   assign item_in.ext_comm_seen     = req_ext_comm_seen;

   assign in_vld_in  = in_take ? req_valid : in_vld_ff;
   assign out_vld_in = out_take ? in_vld_ff : out_vld_ff;

   bsms_step u_step (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORCE_DEEP_MV:          cfg_in.force_deep_mv          = csr_wdata;
            CSR_FORCE_DEEP_SECONDS:     cfg_in.force_deep_seconds     = csr_wdata;
            CSR_LOW_VOLT_MV:            cfg_in.low_volt_mv            = csr_wdata;
            CSR_LOW_VOLT_MINUTES:       cfg_in.low_volt_minutes       = csr_wdata;
            CSR_CHARGE_IDLE_LIMIT:      cfg_in.charge_idle_limit      = csr_wdata;
            CSR_CURRENT_BLOCK_LIMIT:    cfg_in.current_block_limit    = csr_wdata;
            CSR_IDLE_SECONDS_TO_HICCUP: cfg_in.idle_seconds_to_hiccup = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff                     <= 1'b0;
         out_vld_ff                    <= 1'b0;
         state_ff.force_count          <= '0;
         state_ff.low_volt_count       <= '0;
         state_ff.idle_count           <= '0;
         state_ff.comm_pending         <= 1'b0;
         state_ff.mode                 <= MODE_NONE;
         cfg_ff.force_deep_mv          <= RST_FORCE_DEEP_MV;
         cfg_ff.force_deep_seconds     <= RST_FORCE_DEEP_SECONDS;
         cfg_ff.low_volt_mv            <= RST_LOW_VOLT_MV;
         cfg_ff.low_volt_minutes       <= RST_LOW_VOLT_MINUTES;
         cfg_ff.charge_idle_limit      <= RST_CHARGE_IDLE_LIMIT;
         cfg_ff.current_block_limit    <= RST_CURRENT_BLOCK_LIMIT;
         cfg_ff.idle_seconds_to_hiccup <= RST_IDLE_SECONDS_TO_HICCUP;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         cfg_ff     <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_power_mode   = result_ff.power_mode;
   assign rsp_request_made = result_ff.request_made;
   assign rsp_block_mask   = result_ff.block_mask;

endmodule

// ----- verif/battery_sleep_mode_selector_test.sv -----
// ----------------------------------------------------------------------------
// Battery sleep mode selector testbench
// Drives one-second tick items into the selector and checks every decision
// against an in-bench model of the counters, the pending communication flag
// and the sleep mode. Directed ticks cover the thresholds, every block bit and
// every request; random runs of idle, critical, low-voltage and wake ticks
// follow under several register settings and handshake idling patterns, with
// a closing run of critical ticks under extreme register values.
// ----------------------------------------------------------------------------
module battery_sleep_mode_selector_test;
   import bsms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED    = 3'd7;
   localparam int unsigned                CLOSING_TICKS = 40;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [15:0]                req_cell_min_mv = '0;
   logic [15:0]                req_charge_current = '0;
   logic [15:0]                req_discharge_current = '0;
   logic                       req_link_busy = 1'b0;
   logic                       req_key_active = 1'b0;
   logic                       req_flash_busy = 1'b0;
   logic                       req_upgrade_active = 1'b0;
   logic                       req_fault_active = 1'b0;
   logic                       req_led_active = 1'b0;
   logic                       req_aging_active = 1'b0;
   logic                       req_afe_blocked = 1'b0;
   logic                       req_ext_comm_seen = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_power_mode;
   logic [1:0]                 rsp_request_made;
   logic [MASK_WIDTH-1:0]      rsp_block_mask;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   battery_sleep_mode_selector dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cell_min_mv       (req_cell_min_mv),
      .req_charge_current    (req_charge_current),
      .req_discharge_current (req_discharge_current),
      .req_link_busy         (req_link_busy),
      .req_key_active        (req_key_active),
      .req_flash_busy        (req_flash_busy),
      .req_upgrade_active    (req_upgrade_active),
      .req_fault_active      (req_fault_active),
      .req_led_active        (req_led_active),
      .req_aging_active      (req_aging_active),
      .req_afe_blocked       (req_afe_blocked),
      .req_ext_comm_seen     (req_ext_comm_seen),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_power_mode        (rsp_power_mode),
      .rsp_request_made      (rsp_request_made),
      .rsp_block_mask        (rsp_block_mask),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   cfg_type reg_shadow = '{RST_FORCE_DEEP_MV, RST_FORCE_DEEP_SECONDS, RST_LOW_VOLT_MV,
                           RST_LOW_VOLT_MINUTES, RST_CHARGE_IDLE_LIMIT,
                           RST_CURRENT_BLOCK_LIMIT, RST_IDLE_SECONDS_TO_HICCUP};

   logic [15:0]               force_ticks = '0;
   logic [LV_COUNT_WIDTH-1:0] low_ticks = '0;
   logic [15:0]               idle_ticks = '0;
   logic                      comm_waiting = 1'b0;
   mode_type                  mode_now = MODE_NONE;

   item_type   tick_queue[$];
   result_type owed_decisions[$];
   item_type   bus_item;
   int         send_gap_pct = 0;
   int         stall_pct = 0;
   int         mismatches = 0;
   int         ticks_sent = 0;
   int         decisions_seen = 0;
   int         deep_seen = 0;
   int         hiccup_seen = 0;
   int         cancel_seen = 0;

   function automatic result_type sleep_decision(input item_type it);
      result_type            r;
      logic [MASK_WIDTH-1:0] m;
      m = '0;
      m[MASK_CHARGE]    = it.charge_current > reg_shadow.current_block_limit;
      m[MASK_DISCHARGE] = it.discharge_current > reg_shadow.current_block_limit;
      m[MASK_LINK]      = it.link_busy;
      m[MASK_KEY]       = it.key_active;
      m[MASK_FLASH]     = it.flash_busy;
      m[MASK_UPGRADE]   = it.upgrade_active;
      m[MASK_FAULT]     = it.fault_active;
      m[MASK_LED]       = it.led_active;
      m[MASK_AGING]     = it.aging_active;
      m[MASK_AFE]       = it.afe_blocked;
      r.request_made = REQ_NONE;
      if (it.ext_comm_seen) comm_waiting = 1'b1;
      if (it.cell_min_mv <= reg_shadow.force_deep_mv &&
          it.charge_current <= reg_shadow.charge_idle_limit) begin
         idle_ticks = '0;
         if (force_ticks != CNT16_MAX) force_ticks = force_ticks + 16'd1;
         if (force_ticks >= reg_shadow.force_deep_seconds) begin
            mode_now = MODE_DEEP;
            r.request_made = REQ_DEEP;
         end
      end else if (it.cell_min_mv <= reg_shadow.low_volt_mv &&
                   it.charge_current <= reg_shadow.charge_idle_limit) begin
         idle_ticks = '0;
         if (low_ticks != LV_COUNT_MAX) low_ticks = low_ticks + 1'b1;
         if (32'(low_ticks) >= 32'(reg_shadow.low_volt_minutes) * 32'd60) begin
            mode_now = MODE_DEEP;
            r.request_made = REQ_DEEP;
         end
      end else if (it.key_active || it.aging_active) begin
         low_ticks = '0;
         force_ticks = '0;
         idle_ticks = '0;
         if (mode_now == MODE_HICCUP) begin
            mode_now = MODE_NONE;
            r.request_made = REQ_CANCEL;
         end
      end else begin
         low_ticks = '0;
         force_ticks = '0;
         if (m == '0 && comm_waiting) begin
            comm_waiting = 1'b0;
            m[MASK_EXTCOMM] = 1'b1;
         end
         if (m != '0) begin
            idle_ticks = '0;
         end else begin
            if (idle_ticks != CNT16_MAX) idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= reg_shadow.idle_seconds_to_hiccup) begin
               idle_ticks = '0;
               mode_now = MODE_HICCUP;
               r.request_made = REQ_HICCUP;
            end
         end
      end
      r.power_mode = mode_now;
      r.block_mask = m;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            owed_decisions.push_back(sleep_decision(bus_item));
            ticks_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               bus_item = tick_queue.pop_front();
               req_cell_min_mv       <= bus_item.cell_min_mv;
               req_charge_current    <= bus_item.charge_current;
               req_discharge_current <= bus_item.discharge_current;
               req_link_busy         <= bus_item.link_busy;
               req_key_active        <= bus_item.key_active;
               req_flash_busy        <= bus_item.flash_busy;
               req_upgrade_active    <= bus_item.upgrade_active;
               req_fault_active      <= bus_item.fault_active;
               req_led_active        <= bus_item.led_active;
               req_aging_active      <= bus_item.aging_active;
               req_afe_blocked       <= bus_item.afe_blocked;
               req_ext_comm_seen     <= bus_item.ext_comm_seen;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            decisions_seen++;
            if (owed_decisions.size() == 0) begin
               report_mismatch("decision with no item outstanding");
            end else begin
               want = owed_decisions.pop_front();
               if (rsp_power_mode !== want.power_mode)
                  report_mismatch($sformatf("decision %0d power_mode %0d, want %0d",
                                            decisions_seen, rsp_power_mode, want.power_mode));
               if (rsp_request_made !== want.request_made)
                  report_mismatch($sformatf("decision %0d request_made %0d, want %0d",
                                            decisions_seen, rsp_request_made,
                                            want.request_made));
               if (rsp_block_mask !== want.block_mask)
                  report_mismatch($sformatf("decision %0d block_mask %h, want %h",
                                            decisions_seen, rsp_block_mask, want.block_mask));
               case (want.request_made)
                  REQ_DEEP:   deep_seen++;
                  REQ_HICCUP: hiccup_seen++;
                  REQ_CANCEL: cancel_seen++;
                  default: ;
               endcase
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FORCE_DEEP_MV:          reg_shadow.force_deep_mv = val;
         CSR_FORCE_DEEP_SECONDS:     reg_shadow.force_deep_seconds = val;
         CSR_LOW_VOLT_MV:            reg_shadow.low_volt_mv = val;
         CSR_LOW_VOLT_MINUTES:       reg_shadow.low_volt_minutes = val;
         CSR_CHARGE_IDLE_LIMIT:      reg_shadow.charge_idle_limit = val;
         CSR_CURRENT_BLOCK_LIMIT:    reg_shadow.current_block_limit = val;
         CSR_IDLE_SECONDS_TO_HICCUP: reg_shadow.idle_seconds_to_hiccup = val;
         default: ;
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(CSR_FORCE_DEEP_MV, c.force_deep_mv);
      write_reg(CSR_FORCE_DEEP_SECONDS, c.force_deep_seconds);
      write_reg(CSR_LOW_VOLT_MV, c.low_volt_mv);
      write_reg(CSR_LOW_VOLT_MINUTES, c.low_volt_minutes);
      write_reg(CSR_CHARGE_IDLE_LIMIT, c.charge_idle_limit);
      write_reg(CSR_CURRENT_BLOCK_LIMIT, c.current_block_limit);
      write_reg(CSR_IDLE_SECONDS_TO_HICCUP, c.idle_seconds_to_hiccup);
      write_reg(CSR_UNUSED, 16'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (tick_queue.size() != 0 || req_valid || owed_decisions.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic item_type quiet_item(input logic [15:0] mv);
      item_type it;
      it = '0;
      it.cell_min_mv = mv;
      return it;
   endfunction

   function automatic item_type noise_item();
      item_type it;
      it.cell_min_mv       = 16'($urandom);
      it.charge_current    = 16'($urandom);
      it.discharge_current = 16'($urandom);
      {it.link_busy, it.key_active, it.flash_busy, it.upgrade_active, it.fault_active,
       it.led_active, it.aging_active, it.afe_blocked, it.ext_comm_seen} = 9'($urandom);
      return it;
   endfunction

   function automatic item_type idle_item();
      item_type    it;
      int unsigned hi;
      int unsigned n;
      logic [8:0]  f;
      it = '0;
      hi = (reg_shadow.force_deep_mv > reg_shadow.low_volt_mv) ?
           reg_shadow.force_deep_mv : reg_shadow.low_volt_mv;
      if (hi != 65535) begin
         it.cell_min_mv    = 16'($urandom_range(hi + 1, 65535));
         it.charge_current = 16'($urandom_range(0, reg_shadow.current_block_limit));
      end else begin
         it.cell_min_mv    = 16'($urandom);
         it.charge_current = (reg_shadow.charge_idle_limit == CNT16_MAX) ? CNT16_MAX :
            16'($urandom_range(32'(reg_shadow.charge_idle_limit) + 1, 65535));
      end
      it.discharge_current = 16'($urandom_range(0, reg_shadow.current_block_limit));
      f = '0;
      n = $urandom_range(0, 29);
      if (n < 9) f[n] = 1'b1;
      {it.link_busy, it.key_active, it.flash_busy, it.upgrade_active, it.fault_active,
       it.led_active, it.aging_active, it.afe_blocked, it.ext_comm_seen} = f;
      return it;
   endfunction

   function automatic item_type volt_item(input bit critical);
      item_type    it;
      int unsigned fmv;
      fmv = reg_shadow.force_deep_mv;
      it = noise_item();
      if (!critical && reg_shadow.low_volt_mv > reg_shadow.force_deep_mv)
         it.cell_min_mv = 16'($urandom_range(fmv + 1, reg_shadow.low_volt_mv));
      else
         it.cell_min_mv = 16'($urandom_range(0, fmv));
      it.charge_current = 16'($urandom_range(0, reg_shadow.charge_idle_limit));
      {it.link_busy, it.key_active, it.flash_busy, it.upgrade_active, it.fault_active,
       it.led_active, it.aging_active, it.afe_blocked, it.ext_comm_seen} =
         9'($urandom & $urandom & $urandom);
      return it;
   endfunction

   function automatic int unsigned run_cap(input int unsigned limit, input int unsigned top);
      return (limit + 2 < top) ? limit + 2 : top;
   endfunction

   task automatic fill_random(input int count);
      int          made;
      int unsigned kind;
      int unsigned run;
      int unsigned n;
      item_type    it;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(0, 99);
         run = 1;
         if (kind < 40) begin
            run = $urandom_range(1, run_cap(reg_shadow.idle_seconds_to_hiccup, 60));
            repeat (run) tick_queue.push_back(idle_item());
         end else if (kind < 55) begin
            run = $urandom_range(1, run_cap(reg_shadow.force_deep_seconds, 20));
            repeat (run) tick_queue.push_back(volt_item(1'b1));
         end else if (kind < 68) begin
            run = $urandom_range(1, run_cap(32'(reg_shadow.low_volt_minutes) * 60, 70));
            repeat (run) tick_queue.push_back(volt_item(1'b0));
         end else if (kind < 78) begin
            it = idle_item();
            n = $urandom_range(1, 3);
            it.key_active = n[0];
            it.aging_active = n[1];
            tick_queue.push_back(it);
         end else begin
            tick_queue.push_back(noise_item());
         end
         made += run;
      end
   endtask

   task automatic run_phase(input cfg_type c, input int count, input int gap, input int stall);
      drain();
      load_config(c);
      send_gap_pct = gap;
      stall_pct = stall;
      fill_random(count / 2);
      drain();
      fill_random(count - count / 2);
   endtask

   task automatic push_thresholds();
      item_type it;
      tick_queue.push_back(item_type'('0));
      tick_queue.push_back(item_type'('1));
      it = quiet_item(16'd2800); it.charge_current = 16'd5;
      tick_queue.push_back(it);
      it = quiet_item(16'd2801); it.charge_current = 16'd5;
      tick_queue.push_back(it);
      it = quiet_item(16'd3000); it.charge_current = 16'd6; it.discharge_current = 16'd10;
      tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.link_busy = 1'b1; it.ext_comm_seen = 1'b1;
      tick_queue.push_back(it);
      tick_queue.push_back(quiet_item(16'd3600));
      it = quiet_item(16'd3600); it.flash_busy = 1'b1;     tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.upgrade_active = 1'b1; tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.fault_active = 1'b1;   tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.led_active = 1'b1;     tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.afe_blocked = 1'b1;    tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.charge_current = 16'd11;    tick_queue.push_back(it);
      it = quiet_item(16'd3600); it.discharge_current = 16'd11; tick_queue.push_back(it);
   endtask

   task automatic push_mode_changes();
      item_type it;
      repeat (3) tick_queue.push_back(quiet_item(16'd3700));
      it = quiet_item(16'd3700); it.key_active = 1'b1;   tick_queue.push_back(it);
      repeat (3) tick_queue.push_back(quiet_item(16'd3700));
      it = quiet_item(16'd3700); it.aging_active = 1'b1; tick_queue.push_back(it);
      it = quiet_item(16'd3700); it.key_active = 1'b1;   tick_queue.push_back(it);
      repeat (3) tick_queue.push_back(quiet_item(16'd2500));
      it = quiet_item(16'd3700); it.key_active = 1'b1;   tick_queue.push_back(it);
   endtask

   initial begin
      cfg_type c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_thresholds();
      drain();
      c = reg_shadow;
      c.idle_seconds_to_hiccup = 16'd3;
      c.force_deep_seconds = 16'd2;
      load_config(c);
      push_mode_changes();

      c = '{RST_FORCE_DEEP_MV, RST_FORCE_DEEP_SECONDS, RST_LOW_VOLT_MV, RST_LOW_VOLT_MINUTES,
            RST_CHARGE_IDLE_LIMIT, RST_CURRENT_BLOCK_LIMIT, RST_IDLE_SECONDS_TO_HICCUP};
      run_phase(c, 130, 0, 0);
      c = '{16'd3100, 16'd4, 16'd3400, 16'd1, 16'd50, 16'd200, 16'd5};
      run_phase(c, 120, 45, 0);
      c = '0;
      run_phase(c, 120, 0, 45);
      c = '{16'd1000, CNT16_MAX, CNT16_MAX, CNT16_MAX, CNT16_MAX, CNT16_MAX, CNT16_MAX};
      run_phase(c, 70, 7, 7);
      c = '{16'($urandom), 16'($urandom_range(0, 8)), 16'($urandom), 16'($urandom_range(0, 1)),
            16'($urandom), 16'($urandom), 16'($urandom_range(0, 8))};
      run_phase(c, 70, 7, 7);

      drain();
      c = '{CNT16_MAX, CNT16_MAX, 16'd0, 16'd0, CNT16_MAX, 16'($urandom), 16'd1};
      load_config(c);
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (CLOSING_TICKS) tick_queue.push_back(noise_item());

      drain();
      if (owed_decisions.size() != 0)
         report_mismatch($sformatf("%0d decisions never arrived", owed_decisions.size()));
      $display("Sent %0d ticks under seven register settings and four idling patterns,",
               ticks_sent);
      $display("checking %0d decisions: %0d deep, %0d hiccup, %0d cancel requests.",
               decisions_seen, deep_seen, hiccup_seen, cancel_seen);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout: run did not drain");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
